/* hdl/nmea_sentence_field_splitter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the NMEA sentence field splitter
// Clocked implication checks with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FIELD_SPLITTER_MACROS_SVH
`define NMEA_SENTENCE_FIELD_SPLITTER_MACROS_SVH

// Same-cycle implication.
`define NSFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nsfs: same-cycle check failed");

// Next-cycle implication.
`define NSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nsfs: next-cycle check failed");

`endif

/* hdl/nsfs_pkg.sv */
// ----------------------------------------------------------------------------
// nsfs_pkg
// Shared types and constants of the NMEA sentence field splitter.
// ----------------------------------------------------------------------------
package nsfs_pkg;

	localparam int CFG_W    = 40;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = 2;

	// Configuration register indexes.
	localparam logic [1:0] REG_TYPE   = 2'd0;
	localparam logic [1:0] REG_DELIM  = 2'd1;
	localparam logic [1:0] REG_MAXLEN = 2'd2;

	// Characters with a fixed meaning.
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	// Reset value of the sentence type: "GPRMC".
	localparam logic [CFG_W-1:0] TYPE_RESET = 40'h4750524D43;
	localparam logic [7:0]       MAXLEN_RESET = 8'd128;

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_ABORT = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		logic [4:0] field_number;
		logic [4:0] position;
		logic [7:0] body_length;
		logic       last_of_run;
	} res_t;

	// Up to two results produced by one byte.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

/* hdl/nmea_sentence_field_splitter.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_field_splitter
// Splits NMEA-style sentences of a configured type into field characters,
// field-closed, sentence-complete and sentence-aborted results.
//
//   channel | handshake             | payload
//   rx      | rx_valid / rx_ready   | rx_byte
//   res     | res_valid / res_ready | kind, byte_value, field_number,
//           |                       | position, body_length, last_of_run
//   cfg     | cfg_we                | cfg_index, cfg_data
//
// One byte is accepted per cycle while the queue has room; a byte goes from
// the input register through the parser into a four-entry result queue,
// whose head drives the result port. A byte that makes two results hands
// them out one after the other. Input is accepted while the input register
// is empty or the queue has room for two results after the current pop.
// Reset returns the parser to hunting and the registers to GPRMC, ',' and 128.
// ----------------------------------------------------------------------------
module nmea_sentence_field_splitter #(
	parameter int MAX_FIELDS = 32,
	parameter int FIELD_LEN  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [7:0]                 rx_byte,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [1:0]                 kind,
	output logic [7:0]                 byte_value,
	output logic [4:0]                 field_number,
	output logic [4:0]                 position,
	output logic [7:0]                 body_length,
	output logic                       last_of_run,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [nsfs_pkg::CFG_W-1:0] cfg_data
);
	import nsfs_pkg::*;

	logic [CFG_W-1:0] type_q;
	logic [7:0]       delim_q;
	logic [7:0]       maxlen_q;
	logic [7:0]       rx_byte_s1;
	logic             valid_s1;
	logic             go;
	logic             room2;
	logic             pop;
	push_t            push;
	res_t             head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q   <= TYPE_RESET;
			delim_q  <= CH_COMMA;
			maxlen_q <= MAXLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TYPE:   type_q   <= cfg_data;
				REG_DELIM:  delim_q  <= cfg_data[7:0];
				REG_MAXLEN: maxlen_q <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	assign go       = valid_s1 && room2;
	assign rx_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rx_ready)
			valid_s1 <= rx_valid;
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid)
			rx_byte_s1 <= rx_byte;
	end

	nsfs_parser #(
		.MAX_FIELDS(MAX_FIELDS),
		.FIELD_LEN (FIELD_LEN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.rx_byte_s1(rx_byte_s1),
		.cfg_type  (type_q),
		.cfg_delim (delim_q),
		.cfg_maxlen(maxlen_q),
		.push      (push)
	);

	assign pop = res_valid && res_ready;

	nsfs_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.room2     (room2),
		.head_valid(res_valid),
		.head      (head)
	);

	assign kind         = head.kind;
	assign byte_value   = head.byte_value;
	assign field_number = head.field_number;
	assign position     = head.position;
	assign body_length  = head.body_length;
	assign last_of_run  = head.last_of_run;

endmodule

/* hdl/nsfs_parser.sv */
// ----------------------------------------------------------------------------
// nsfs_parser
// Sentence state machine: hunts for the start marker, checks the type and
// splits the body into fields, producing up to two results per byte.
// ----------------------------------------------------------------------------
module nsfs_parser #(
	parameter int MAX_FIELDS = 32,
	parameter int FIELD_LEN  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [7:0]                rx_byte_s1,
	input  logic [nsfs_pkg::CFG_W-1:0] cfg_type,
	input  logic [7:0]                cfg_delim,
	input  logic [7:0]                cfg_maxlen,
	output nsfs_pkg::push_t           push
);
	import nsfs_pkg::*;

	localparam int FW = $clog2(MAX_FIELDS);
	localparam int PW = $clog2(FIELD_LEN + 1);

	typedef enum logic [1:0] {PH_HUNT, PH_TYPE, PH_SKIP, PH_BODY} phase_t;

	phase_t        phase_q, phase_d;
	logic [2:0]    tcnt_q, tcnt_d;
	logic          tmatch_q, tmatch_d;
	logic [7:0]    body_q, body_d;
	logic [FW-1:0] field_q, field_d;
	logic [PW-1:0] pos_q, pos_d;

	logic [7:0] want;
	logic       want_ok;
	logic [7:0] body_inc;
	res_t       r0, r1;
	logic [1:0] cnt;

	always_comb begin
		want_ok = 1'b1;
		case (tcnt_q)
			3'd0: want = cfg_type[39:32];
			3'd1: want = cfg_type[31:24];
			3'd2: want = cfg_type[23:16];
			3'd3: want = cfg_type[15:8];
			3'd4: want = cfg_type[7:0];
			default: begin
				want    = 8'h00;
				want_ok = 1'b0;
			end
		endcase
	end

	assign body_inc = body_q + 8'd1;

	always_comb begin
		phase_d  = phase_q;
		tcnt_d   = tcnt_q;
		tmatch_d = tmatch_q;
		body_d   = body_q;
		field_d  = field_q;
		pos_d    = pos_q;
		cnt      = 2'd0;

		r0.kind         = KIND_CHAR;
		r0.byte_value   = 8'h00;
		r0.field_number = 5'(field_q);
		r0.position     = 5'(pos_q);
		r0.body_length  = body_inc;
		r0.last_of_run  = 1'b1;
		r1              = r0;

		case (phase_q)
			PH_HUNT: begin
				if (rx_byte_s1 == CH_START) begin
					phase_d  = PH_TYPE;
					tcnt_d   = 3'd0;
					tmatch_d = 1'b1;
				end
			end
			PH_TYPE: begin
				if (tcnt_q >= 3'd4) begin
					phase_d  = (tmatch_q && want_ok && rx_byte_s1 == want) ? PH_SKIP : PH_HUNT;
					tcnt_d   = 3'd0;
					tmatch_d = 1'b1;
				end else begin
					tcnt_d   = tcnt_q + 3'd1;
					tmatch_d = tmatch_q && want_ok && rx_byte_s1 == want;
				end
			end
			PH_SKIP: begin
				phase_d = PH_BODY;
				body_d  = 8'd0;
				field_d = '0;
				pos_d   = '0;
			end
			PH_BODY: begin
				cnt = 2'd1;
				if (rx_byte_s1 == CH_STAR) begin
					// The star is not counted in the body length.
					r0.kind        = KIND_DONE;
					r0.body_length = body_q;
					phase_d        = PH_HUNT;
				end else begin
					body_d = body_inc;
					if (body_inc >= cfg_maxlen) begin
						r0.kind = KIND_ABORT;
						phase_d = PH_HUNT;
					end else if (rx_byte_s1 == cfg_delim) begin
						if (field_q == FW'(MAX_FIELDS - 1)) begin
							r0.kind = KIND_ABORT;
							phase_d = PH_HUNT;
						end else begin
							field_d = field_q + 1'b1;
							pos_d   = '0;
							if (pos_q == '0) begin
								// An empty field gets a filler character first.
								cnt              = 2'd2;
								r0.byte_value    = CH_ZERO;
								r0.last_of_run   = 1'b0;
								r1.kind          = KIND_CLOSE;
								r1.position      = 5'd1;
							end else begin
								r0.kind = KIND_CLOSE;
							end
						end
					end else if (pos_q == PW'(FIELD_LEN)) begin
						r0.kind = KIND_ABORT;
						phase_d = PH_HUNT;
					end else begin
						r0.byte_value = rx_byte_s1;
						pos_d         = pos_q + 1'b1;
					end
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			tcnt_q   <= 3'd0;
			tmatch_q <= 1'b1;
			body_q   <= 8'd0;
			field_q  <= '0;
			pos_q    <= '0;
		end else if (go) begin
			phase_q  <= phase_d;
			tcnt_q   <= tcnt_d;
			tmatch_q <= tmatch_d;
			body_q   <= body_d;
			field_q  <= field_d;
			pos_q    <= pos_d;
		end
	end

	assign push.cnt = go ? cnt : 2'd0;
	assign push.r0  = r0;
	assign push.r1  = r1;

endmodule

/* hdl/nsfs_out_fifo.sv */
// ----------------------------------------------------------------------------
// nsfs_out_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module nsfs_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  nsfs_pkg::push_t push,
	input  logic            pop,
	output logic            room2,
	output logic            head_valid,
	output nsfs_pkg::res_t  head
);
	import nsfs_pkg::*;

	res_t             mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q, rp_q;
	logic [OQ_AW:0]   cnt_q;
	logic [OQ_AW:0]   cnt_left;

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];

	// Two free slots after this cycle's pop are needed for any byte.
	assign cnt_left = cnt_q - {{OQ_AW{1'b0}}, pop};
	assign room2    = cnt_left <= (OQ_AW + 1)'(OQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wp_q] <= push.r0;
		if (push.cnt == 2'd2)
			mem_q[wp_q + 1'b1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OQ_AW'(push.cnt);
			rp_q  <= rp_q + {{(OQ_AW-1){1'b0}}, pop};
			cnt_q <= cnt_left + (OQ_AW + 1)'(push.cnt);
		end
	end

endmodule

/* hdl/nsfs_checker.sv */
// ----------------------------------------------------------------------------
// nsfs_checker
// Port-level checks on the result channel of the field splitter.
// ----------------------------------------------------------------------------
`include "nmea_sentence_field_splitter_macros.svh"

module nsfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] kind,
	input logic [7:0] byte_value,
	input logic [4:0] field_number,
	input logic [4:0] position,
	input logic [7:0] body_length,
	input logic       last_of_run
);
	import nsfs_pkg::*;

	// A stalled item holds its payload.
	`NSFS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable({kind, byte_value, field_number, position, body_length, last_of_run}))

	// Only character items carry a byte.
	`NSFS_ASSERT_NOW(a_byte_zero, clk, arst_n, res_valid && kind != KIND_CHAR, byte_value == 8'h00)

	// A closed field is never shorter than one character.
	`NSFS_ASSERT_NOW(a_close_len, clk, arst_n, res_valid && kind == KIND_CLOSE, position != 5'd0)

	// Complete and abort are always the final item of their byte.
	`NSFS_ASSERT_NOW(a_end_last, clk, arst_n, res_valid && (kind == KIND_DONE || kind == KIND_ABORT), last_of_run)

endmodule

bind nmea_sentence_field_splitter nsfs_checker u_nsfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_ready   (res_ready),
	.kind        (kind),
	.byte_value  (byte_value),
	.field_number(field_number),
	.position    (position),
	.body_length (body_length),
	.last_of_run (last_of_run)
);

/* dv/tb_nmea_sentence_field_splitter.sv */
// ----------------------------------------------------------------------------
// tb_nmea_sentence_field_splitter
// Drives byte streams into the NMEA sentence field splitter. The streams
// hold well-formed sentences with random content, broken sentences and
// noise. A built-in parser model predicts every result, and each result is
// checked field by field in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_field_splitter;

	import nsfs_pkg::*;

	localparam int         N_FIELDS     = 32;
	localparam int         N_CHARS      = 16;
	localparam int         HALF_PERIOD  = 4;
	localparam longint     LIMIT_CYCLES = 2_000_000;
	localparam logic [1:0] REG_UNUSED   = 2'd3;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_TYPE,
		PH_SKIP,
		PH_BODY
	} parse_phase_t;

	class field_result_tracker;
		logic [39:0]  type_reg;
		logic [7:0]   delim_reg;
		logic [7:0]   maxlen_reg;
		parse_phase_t phase;
		int           type_count;
		bit           type_ok;
		logic [7:0]   body_count;
		int           field_idx;
		int           char_pos;
		res_t         pending_results[$];
		res_t         run[$];
		int           mismatches;

		function new();
			type_reg   = TYPE_RESET;
			delim_reg  = CH_COMMA;
			maxlen_reg = MAXLEN_RESET;
			phase      = PH_HUNT;
			type_count = 0;
			type_ok    = 1'b1;
			body_count = '0;
			field_idx  = 0;
			char_pos   = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [39:0] value);
			case (idx)
				REG_TYPE:   type_reg   = value;
				REG_DELIM:  delim_reg  = value[7:0];
				REG_MAXLEN: maxlen_reg = value[7:0];
				default:    ;
			endcase
		endfunction

		function void emit(kind_t k, logic [7:0] value, int pos);
			res_t r;
			r.kind         = k;
			r.byte_value   = value;
			r.field_number = field_idx[4:0];
			r.position     = pos[4:0];
			r.body_length  = body_count;
			r.last_of_run  = 1'b0;
			run.push_back(r);
		endfunction

		// Advances the parser by one accepted byte and queues its results.
		function void note_byte(logic [7:0] c);
			logic [7:0] want;
			int         len;
			run.delete();
			case (phase)
				PH_HUNT: begin
					if (c == CH_START) begin
						phase      = PH_TYPE;
						type_count = 0;
						type_ok    = 1'b1;
					end
				end
				PH_TYPE: begin
					want = type_reg[8 * (4 - type_count) +: 8];
					if (c != want)
						type_ok = 1'b0;
					type_count++;
					if (type_count >= 5) begin
						phase      = type_ok ? PH_SKIP : PH_HUNT;
						type_count = 0;
						type_ok    = 1'b1;
					end
				end
				PH_SKIP: begin
					phase      = PH_BODY;
					body_count = '0;
					field_idx  = 0;
					char_pos   = 0;
				end
				default: begin
					if (c == CH_STAR) begin
						emit(KIND_DONE, 8'h00, char_pos);
						phase = PH_HUNT;
					end else begin
						body_count = body_count + 8'd1;
						if (body_count >= maxlen_reg) begin
							emit(KIND_ABORT, 8'h00, char_pos);
							phase = PH_HUNT;
						end else if (c == delim_reg) begin
							if (field_idx + 1 >= N_FIELDS) begin
								emit(KIND_ABORT, 8'h00, char_pos);
								phase = PH_HUNT;
							end else begin
								len = char_pos;
								// An empty field is filled with a single '0'.
								if (len == 0) begin
									emit(KIND_CHAR, CH_ZERO, 0);
									len = 1;
								end
								emit(KIND_CLOSE, 8'h00, len);
								field_idx++;
								char_pos = 0;
							end
						end else if (char_pos >= N_CHARS) begin
							emit(KIND_ABORT, 8'h00, char_pos);
							phase = PH_HUNT;
						end else begin
							emit(KIND_CHAR, c, char_pos);
							char_pos++;
						end
					end
				end
			endcase
			if (run.size() > 0)
				run[run.size() - 1].last_of_run = 1'b1;
			foreach (run[i])
				pending_results.push_back(run[i]);
		endfunction

		function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
			if (exp !== act) begin
				$error("%s expected %0d actual %0d", name, exp, act);
				mismatches++;
			end
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: kind %0d byte %0d field %0d",
					got.kind, got.byte_value, got.field_number);
				mismatches++;
				return;
			end
			exp = pending_results.pop_front();
			compare_field("kind", 8'(exp.kind), 8'(got.kind));
			compare_field("byte_value", exp.byte_value, got.byte_value);
			compare_field("field_number", 8'(exp.field_number), 8'(got.field_number));
			compare_field("position", 8'(exp.position), 8'(got.position));
			compare_field("body_length", exp.body_length, got.body_length);
			compare_field("last_of_run", 8'(exp.last_of_run), 8'(got.last_of_run));
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        rx_valid  = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte   = 8'h00;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic [4:0]  field_number;
	logic [4:0]  position;
	logic [7:0]  body_length;
	logic        last_of_run;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_TYPE;
	logic [39:0] cfg_data  = '0;

	field_result_tracker sb = new();
	int                  bytes_sent = 0;
	bit                  no_idle    = 1'b0;

	nmea_sentence_field_splitter #(
		.MAX_FIELDS(N_FIELDS),
		.FIELD_LEN (N_CHARS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.kind        (kind),
		.byte_value  (byte_value),
		.field_number(field_number),
		.position    (position),
		.body_length (body_length),
		.last_of_run (last_of_run),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_STAR || c == sb.delim_reg);
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!rx_ready);
		sb.note_byte(b);
		bytes_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One sentence of the configured type with random content; some are
	// broken on purpose: wrong type, oversized fields, too many fields, no '*'.
	task automatic send_sentence();
		logic [39:0] t;
		int          n_fields;
		int          len;
		int          bad;
		t = sb.type_reg;
		if ($urandom_range(0, 7) == 0) begin
			bad = $urandom_range(0, 4);
			t[8 * bad +: 8] = t[8 * bad +: 8] ^ 8'($urandom_range(1, 255));
		end
		send_byte(CH_START);
		for (int i = 4; i >= 0; i--)
			send_byte(t[8 * i +: 8]);
		send_byte(8'($urandom_range(0, 255)));
		n_fields = ($urandom_range(0, 14) == 0) ? $urandom_range(31, 34) : $urandom_range(1, 8);
		for (int f = 0; f < n_fields; f++) begin
			if (f > 0)
				send_byte(sb.delim_reg);
			len = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 17) : $urandom_range(0, 5);
			if (n_fields > 30)
				len = $urandom_range(0, 2);
			for (int k = 0; k < len; k++)
				send_byte(body_char());
		end
		if ($urandom_range(0, 7) != 0)
			send_byte(CH_STAR);
	endtask

	task automatic random_phase(input int n_bytes);
		int stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_sentence();
			end
		end
	endtask

	// Waits until every expected result has come and the pipeline is empty.
	task automatic settle();
		rx_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic program_regs(input logic [39:0] t, input logic [7:0] d,
			input logic [7:0] m, input bit poke_unused);
		logic [39:0] junk;
		junk = {8'($urandom_range(0, 255)), 32'($urandom)};
		cfg_we    <= 1'b1;
		cfg_index <= REG_TYPE;
		cfg_data  <= t;
		sb.set_reg(REG_TYPE, t);
		@(posedge clk);
		cfg_index <= REG_DELIM;
		cfg_data  <= {32'h0, d};
		sb.set_reg(REG_DELIM, {32'h0, d});
		@(posedge clk);
		cfg_index <= REG_MAXLEN;
		cfg_data  <= {32'h0, m};
		sb.set_reg(REG_MAXLEN, {32'h0, m});
		@(posedge clk);
		if (poke_unused) begin
			// Writes to the unused index must change nothing.
			cfg_index <= REG_UNUSED;
			cfg_data  <= junk;
			sb.set_reg(REG_UNUSED, junk);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		logic [7:0] seq[$];
		// Extremes, a GPRMC sentence with an empty field and '$' in the body,
		// then a sentence of the wrong type.
		seq = '{8'h00, 8'hFF, CH_START, "G", "P", "R", "M", "C", CH_COMMA,
			"A", CH_COMMA, CH_COMMA, 8'hFF, CH_START, CH_STAR,
			CH_START, "G", "P", "R", "M", "X", CH_COMMA};
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// Result side: random stalls, plus one long hold-off that fills the block.
	initial begin
		res_t got;
		int   n_got;
		int   stall;
		bit   held;
		n_got = 0;
		stall = 0;
		held  = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				got.kind         = kind_t'(kind);
				got.byte_value   = byte_value;
				got.field_number = field_number;
				got.position     = position;
				got.body_length  = body_length;
				got.last_of_run  = last_of_run;
				sb.check_result(got);
				n_got++;
			end
			if (!held && n_got >= 60) begin
				held = 1'b1;
				res_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			if (stall > 0) begin
				res_ready <= 1'b0;
				stall--;
			end else begin
				stall = pick_gap();
				res_ready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		settle();
		program_regs(40'h4750474741, CH_COMMA, 8'd255, 1'b0);
		random_phase(180);
		settle();
		program_regs(40'h0, 8'h00, 8'd1, 1'b0);
		random_phase(120);
		settle();
		program_regs(40'hFFFFFFFFFF, 8'hFF, 8'd255, 1'b0);
		random_phase(180);
		settle();
		// The delimiter equals '*', which must still complete the sentence.
		program_regs({8'($urandom_range(0, 255)), 32'($urandom)}, CH_STAR, 8'd40, 1'b1);
		random_phase(170);
		settle();
		no_idle = 1'b1;
		program_regs({8'($urandom_range(0, 255)), 32'($urandom)},
			8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)), 1'b1);
		random_phase(170);
		settle();
		no_idle = 1'b0;
		program_regs(TYPE_RESET, CH_COMMA, 8'd20, 1'b0);
		random_phase(180);
		settle();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/nsfs_pkg.sv
hdl/nsfs_parser.sv
hdl/nsfs_out_fifo.sv
hdl/nmea_sentence_field_splitter.sv
hdl/nsfs_checker.sv
dv/tb_nmea_sentence_field_splitter.sv
